[hdl/tta_pkg.sv]
// Shared types and constants of the tensor transpose address generator.
package tta_pkg;

   localparam int HW_AXES = 4;
   localparam int AXIS_BITS = 2;
   localparam int RANK_BITS = 3;
   localparam int PERM_BITS = HW_AXES * AXIS_BITS;
   localparam int CSR_INDEX_BITS = 3;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_RANK        = 3'd0,
      CSR_PERMUTATION = 3'd1,
      CSR_REVERSE     = 3'd2,
      CSR_SHAPE0      = 3'd3,
      CSR_SHAPE1      = 3'd4,
      CSR_SHAPE2      = 3'd5,
      CSR_SHAPE3      = 3'd6
   } csr_index_type;

   typedef enum logic [1:0] {
      ERR_NONE  = 2'd0,
      ERR_PERM  = 2'd1,
      ERR_RANGE = 2'd2
   } error_code_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_MAP,
      ST_EMIT
   } back_state_type;

   // One classified request as it travels from the front end to the back end.
   typedef struct packed {
      logic                                 restart;
      logic                                 bad;
      logic [RANK_BITS-1:0]                 rank;
      logic [HW_AXES-1:0][AXIS_BITS-1:0]    perm;
   } tta_cmd_type;

endpackage

[hdl/tensor_transpose_address_generator_unit.sv]
// Top level of the tensor transpose gather address generator.
//
//   Channel  Direction  Handshake            Beat contents
//   req_     in         req_valid/req_stall  restart
//   rsp_     out        rsp_valid/rsp_stall  dest_index, src_index, last, error
//   csr_     in         csr_valid/csr_ready  csr_index, csr_data
//
// An advance beat is handled in the idle state of the back end, so a steady stream of
// advance beats yields one result per cycle while rsp_stall is low. A restart beat runs
// the shared shift-add multiplier one extent bit per cycle, then maps each output axis.
// Reset is synchronous and leaves a pass of one element with no error.
// A two-entry queue between front and back raises req_stall when full; rsp_stall
// holds the result register and stops the back end only when it has a new result.
module tensor_transpose_address_generator_unit #(
   parameter int MAX_RANK    = 4,
   parameter int INDEX_BITS  = 32,
   parameter int EXTENT_BITS = 16,
   localparam int CSR_DATA_BITS = (EXTENT_BITS > 8) ? EXTENT_BITS : 8
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [tta_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]           csr_data,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic                               req_restart,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [INDEX_BITS-1:0]              rsp_dest_index,
   output logic [INDEX_BITS-1:0]              rsp_src_index,
   output logic                               rsp_last,
   output logic [1:0]                         rsp_error
);

   logic                                         push_valid;
   tta_pkg::tta_cmd_type                         push_data;
   logic                                         queue_full;
   logic                                         pop;
   logic                                         pop_valid;
   tta_pkg::tta_cmd_type                         pop_data;
   logic [tta_pkg::HW_AXES-1:0][EXTENT_BITS-1:0] shape;

   tta_front #(
      .MAX_RANK    (MAX_RANK),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_restart (req_restart),
      .queue_full  (queue_full),
      .push_valid  (push_valid),
      .push_data   (push_data),
      .shape       (shape)
   );

   tta_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data)
   );

   tta_back #(
      .MAX_RANK    (MAX_RANK),
      .INDEX_BITS  (INDEX_BITS),
      .EXTENT_BITS (EXTENT_BITS)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .pop_valid      (pop_valid),
      .pop_data       (pop_data),
      .pop            (pop),
      .shape          (shape),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_dest_index (rsp_dest_index),
      .rsp_src_index  (rsp_src_index),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

endmodule

[hdl/tta_front.sv]
// Front end: configuration registers, request intake and permutation check.
module tta_front #(
   parameter int MAX_RANK    = 4,
   parameter int EXTENT_BITS = 16,
   localparam int CSR_DATA_BITS = (EXTENT_BITS > 8) ? EXTENT_BITS : 8
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          csr_valid,
   output logic                                          csr_ready,
   input  logic [tta_pkg::CSR_INDEX_BITS-1:0]            csr_index,
   input  logic [CSR_DATA_BITS-1:0]                      csr_data,
   input  logic                                          req_valid,
   output logic                                          req_stall,
   input  logic                                          req_restart,
   input  logic                                          queue_full,
   output logic                                          push_valid,
   output tta_pkg::tta_cmd_type                          push_data,
   output logic [tta_pkg::HW_AXES-1:0][EXTENT_BITS-1:0]  shape
);

   localparam int AXES = (MAX_RANK < tta_pkg::HW_AXES) ? MAX_RANK : tta_pkg::HW_AXES;

   logic [tta_pkg::RANK_BITS-1:0]                rank_ff, rank_in;
   logic [tta_pkg::PERM_BITS-1:0]                perm_ff, perm_in;
   logic                                         reverse_ff, reverse_in;
   logic [tta_pkg::HW_AXES-1:0][EXTENT_BITS-1:0] shape_ff, shape_in;

   assign csr_ready = 1'b1;

   always_comb begin
      rank_in    = rank_ff;
      perm_in    = perm_ff;
      reverse_in = reverse_ff;
      shape_in   = shape_ff;
      if (csr_valid) begin
         case (tta_pkg::csr_index_type'(csr_index))
            tta_pkg::CSR_RANK:        rank_in = csr_data[tta_pkg::RANK_BITS-1:0];
            tta_pkg::CSR_PERMUTATION: perm_in = csr_data[tta_pkg::PERM_BITS-1:0];
            tta_pkg::CSR_REVERSE:     reverse_in = csr_data[0];
            tta_pkg::CSR_SHAPE0:      shape_in[0] = csr_data[EXTENT_BITS-1:0];
            tta_pkg::CSR_SHAPE1:      shape_in[1] = csr_data[EXTENT_BITS-1:0];
            tta_pkg::CSR_SHAPE2:      shape_in[2] = csr_data[EXTENT_BITS-1:0];
            tta_pkg::CSR_SHAPE3:      shape_in[3] = csr_data[EXTENT_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff    <= tta_pkg::RANK_BITS'(1);
         perm_ff    <= tta_pkg::PERM_BITS'(228);
         reverse_ff <= 1'b1;
         for (int i = 0; i < tta_pkg::HW_AXES; i++) begin
            shape_ff[i] <= EXTENT_BITS'(1);
         end
      end else begin
         rank_ff    <= rank_in;
         perm_ff    <= perm_in;
         reverse_ff <= reverse_in;
         shape_ff   <= shape_in;
      end
   end

   // A permutation is complete when every axis below the rank is named once.
   always_comb begin
      logic [tta_pkg::HW_AXES-1:0]          seen;
      logic [tta_pkg::HW_AXES-1:0]          expect_mask;
      logic [tta_pkg::RANK_BITS-1:0]        rev_axis;
      logic [tta_pkg::AXIS_BITS-1:0]        src_axis;
      logic                                 rank_ok;
      seen        = '0;
      expect_mask = '0;
      rev_axis    = '0;
      src_axis    = '0;
      push_data   = '0;
      rank_ok     = (rank_ff >= tta_pkg::RANK_BITS'(1)) &&
                    (rank_ff <= tta_pkg::RANK_BITS'(AXES));
      for (int i = 0; i < tta_pkg::HW_AXES; i++) begin
         if (tta_pkg::RANK_BITS'(i) < rank_ff) begin
            rev_axis = rank_ff - tta_pkg::RANK_BITS'(i) - tta_pkg::RANK_BITS'(1);
            src_axis = reverse_ff ? rev_axis[tta_pkg::AXIS_BITS-1:0]
                                  : perm_ff[tta_pkg::AXIS_BITS*i +: tta_pkg::AXIS_BITS];
            push_data.perm[i] = src_axis;
            expect_mask[i] = 1'b1;
            if ({1'b0, src_axis} < rank_ff) begin
               seen[src_axis] = 1'b1;
            end
         end
      end
      push_data.restart = req_restart;
      push_data.rank    = rank_ff;
      push_data.bad     = !rank_ok || (seen != expect_mask);
   end

   assign push_valid = req_valid;
   assign req_stall  = queue_full;
   assign shape      = shape_ff;

endmodule

[hdl/tta_queue.sv]
// Two-entry command queue between the front end and the back end.
module tta_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push_valid,
   input  tta_pkg::tta_cmd_type push_data,
   output logic                 full,
   input  logic                 pop,
   output logic                 pop_valid,
   output tta_pkg::tta_cmd_type pop_data
);

   tta_pkg::tta_cmd_type slot_ff [2];
   tta_pkg::tta_cmd_type slot_in [2];
   logic [1:0] count_ff, count_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic       push;

   assign full      = (count_ff == 2'd2);
   assign pop_valid = (count_ff != 2'd0);
   assign pop_data  = slot_ff[rd_ptr_ff];
   assign push      = push_valid && !full;

   always_comb begin
      slot_in   = slot_ff;
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         slot_in[wr_ptr_ff] = push_data;
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      if (reset) begin
         count_ff  <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

endmodule

[hdl/tta_back.sv]
// Back end: stride setup sequencer, output-order odometer and result register.
module tta_back #(
   parameter int MAX_RANK    = 4,
   parameter int INDEX_BITS  = 32,
   parameter int EXTENT_BITS = 16
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          pop_valid,
   input  tta_pkg::tta_cmd_type                          pop_data,
   output logic                                          pop,
   input  logic [tta_pkg::HW_AXES-1:0][EXTENT_BITS-1:0]  shape,
   output logic                                          rsp_valid,
   input  logic                                          rsp_stall,
   output logic [INDEX_BITS-1:0]                         rsp_dest_index,
   output logic [INDEX_BITS-1:0]                         rsp_src_index,
   output logic                                          rsp_last,
   output logic [1:0]                                    rsp_error
);

   localparam int AXES     = (MAX_RANK < tta_pkg::HW_AXES) ? MAX_RANK : tta_pkg::HW_AXES;
   localparam int K_BITS   = (AXES > 1) ? $clog2(AXES) : 1;
   localparam int BIT_BITS = $clog2(EXTENT_BITS);
   localparam int N        = INDEX_BITS;
   localparam int E        = EXTENT_BITS;

   tta_pkg::back_state_type state_ff, state_in;

   // Odometer state and per-axis source step.
   logic [E-1:0]  coord_ff [AXES];
   logic [E-1:0]  coord_in [AXES];
   logic [E-1:0]  ext_ff   [AXES];
   logic [E-1:0]  ext_in   [AXES];
   logic [N-1:0]  delta_ff [AXES];
   logic [N-1:0]  delta_in [AXES];
   logic [N-1:0]  src_ff, src_in;
   logic [N-1:0]  dest_ff, dest_in;
   tta_pkg::error_code_type err_ff, err_in;

   // Setup scratch: input strides and stride times extent for each input axis.
   logic [N-1:0]  in_stride_ff [tta_pkg::HW_AXES];
   logic [N-1:0]  in_stride_in [tta_pkg::HW_AXES];
   logic [N-1:0]  span_ff      [tta_pkg::HW_AXES];
   logic [N-1:0]  span_in      [tta_pkg::HW_AXES];
   logic [tta_pkg::RANK_BITS-1:0]                      rank_ff, rank_in;
   logic [tta_pkg::HW_AXES-1:0][tta_pkg::AXIS_BITS-1:0] perm_ff, perm_in;
   logic [tta_pkg::AXIS_BITS-1:0] ax_ff, ax_in;
   logic [K_BITS-1:0]   k_ff, k_in;
   logic [BIT_BITS-1:0] bit_cnt_ff, bit_cnt_in;
   logic [E-1:0]        mul_e_ff, mul_e_in;
   logic [N+1:0]        acc_ff, acc_in;
   logic [N:0]          prod_ff, prod_in;
   logic [N-1:0]        rewind_ff, rewind_in;

   // Result register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic [N-1:0]  rsp_dest_ff, rsp_dest_in;
   logic [N-1:0]  rsp_src_ff, rsp_src_in;
   logic          rsp_last_ff, rsp_last_in;
   tta_pkg::error_code_type rsp_err_ff, rsp_err_in;

   logic          out_free;
   logic [E-1:0]  coord_adv [AXES];
   logic          wrapped;
   logic [N-1:0]  delta_pick;
   logic          last_adv;
   logic          last_cur;
   logic [tta_pkg::AXIS_BITS-1:0] shape_sel;
   logic [tta_pkg::AXIS_BITS-1:0] map_axis;
   logic [tta_pkg::RANK_BITS-1:0] first_axis;
   logic [E-1:0]  shape_eff;
   logic [N+1:0]  acc_next;
   logic          acc_over;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Odometer step: the innermost axis that can still count up takes the carry.
   always_comb begin
      logic carry;
      logic [E:0] nxt;
      carry      = 1'b1;
      delta_pick = '0;
      for (int i = AXES - 1; i >= 0; i--) begin
         nxt = {1'b0, coord_ff[i]} + (E+1)'(1);
         coord_adv[i] = coord_ff[i];
         if (carry) begin
            if (nxt < {1'b0, ext_ff[i]}) begin
               coord_adv[i] = nxt[E-1:0];
               delta_pick   = delta_ff[i];
               carry        = 1'b0;
            end else begin
               coord_adv[i] = '0;
            end
         end
      end
      wrapped = carry;
   end

   always_comb begin
      last_adv = 1'b1;
      last_cur = 1'b1;
      for (int i = 0; i < AXES; i++) begin
         if (({1'b0, coord_adv[i]} + (E+1)'(1)) != {1'b0, ext_ff[i]}) begin
            last_adv = 1'b0;
         end
         if (({1'b0, coord_ff[i]} + (E+1)'(1)) != {1'b0, ext_ff[i]}) begin
            last_cur = 1'b0;
         end
      end
   end

   // One shared read port on the shape registers serves setup and mapping.
   assign first_axis = pop_data.rank - tta_pkg::RANK_BITS'(1);
   assign map_axis   = perm_ff[tta_pkg::AXIS_BITS'(k_ff)];

   always_comb begin
      case (state_ff)
         tta_pkg::ST_IDLE: shape_sel = first_axis[tta_pkg::AXIS_BITS-1:0];
         tta_pkg::ST_MAP:  shape_sel = map_axis;
         default:          shape_sel = ax_ff - tta_pkg::AXIS_BITS'(1);
      endcase
      shape_eff = (shape[shape_sel] == '0) ? E'(1) : shape[shape_sel];
   end

   // Shift-add step, most significant extent bit first.
   assign acc_next = {acc_ff[N:0], 1'b0} + (mul_e_ff[E-1] ? {1'b0, prod_ff} : '0);
   assign acc_over = acc_next[N+1] || (acc_next[N] && (acc_next[N-1:0] != '0));

   always_comb begin
      state_in     = state_ff;
      coord_in     = coord_ff;
      ext_in       = ext_ff;
      delta_in     = delta_ff;
      src_in       = src_ff;
      dest_in      = dest_ff;
      err_in       = err_ff;
      in_stride_in = in_stride_ff;
      span_in      = span_ff;
      rank_in      = rank_ff;
      perm_in      = perm_ff;
      ax_in        = ax_ff;
      k_in         = k_ff;
      bit_cnt_in   = bit_cnt_ff;
      mul_e_in     = mul_e_ff;
      acc_in       = acc_ff;
      prod_in      = prod_ff;
      rewind_in    = rewind_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_dest_in  = rsp_dest_ff;
      rsp_src_in   = rsp_src_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      pop          = 1'b0;

      case (state_ff)
         tta_pkg::ST_IDLE: begin
            if (pop_valid && !pop_data.restart) begin
               if (out_free) begin
                  pop      = 1'b1;
                  coord_in = coord_adv;
                  dest_in  = wrapped ? '0 : dest_ff + N'(1);
                  src_in   = wrapped ? '0 : src_ff + delta_pick;
                  rsp_valid_in = 1'b1;
                  rsp_dest_in  = dest_in;
                  rsp_src_in   = src_in;
                  rsp_last_in  = last_adv;
                  rsp_err_in   = err_ff;
               end
            end else if (pop_valid) begin
               pop     = 1'b1;
               src_in  = '0;
               dest_in = '0;
               for (int i = 0; i < AXES; i++) begin
                  coord_in[i] = '0;
                  ext_in[i]   = E'(1);
                  delta_in[i] = '0;
               end
               if (pop_data.bad) begin
                  err_in   = tta_pkg::ERR_PERM;
                  state_in = tta_pkg::ST_EMIT;
               end else begin
                  err_in     = tta_pkg::ERR_NONE;
                  rank_in    = pop_data.rank;
                  perm_in    = pop_data.perm;
                  ax_in      = first_axis[tta_pkg::AXIS_BITS-1:0];
                  in_stride_in[first_axis[tta_pkg::AXIS_BITS-1:0]] = N'(1);
                  prod_in    = (N+1)'(1);
                  acc_in     = '0;
                  mul_e_in   = shape_eff;
                  bit_cnt_in = BIT_BITS'(E - 1);
                  state_in   = tta_pkg::ST_MUL;
               end
            end
         end

         tta_pkg::ST_MUL: begin
            mul_e_in = {mul_e_ff[E-2:0], 1'b0};
            acc_in   = acc_next;
            if (acc_over) begin
               // The running product only grows, so the first excess is final.
               err_in   = tta_pkg::ERR_RANGE;
               state_in = tta_pkg::ST_EMIT;
            end else if (bit_cnt_ff == '0) begin
               span_in[ax_ff] = acc_next[N-1:0];
               prod_in        = acc_next[N:0];
               acc_in         = '0;
               if (ax_ff == '0) begin
                  k_in      = K_BITS'(AXES - 1);
                  rewind_in = '0;
                  state_in  = tta_pkg::ST_MAP;
               end else begin
                  ax_in      = ax_ff - tta_pkg::AXIS_BITS'(1);
                  in_stride_in[ax_ff - tta_pkg::AXIS_BITS'(1)] = acc_next[N-1:0];
                  mul_e_in   = shape_eff;
                  bit_cnt_in = BIT_BITS'(E - 1);
               end
            end else begin
               bit_cnt_in = bit_cnt_ff - BIT_BITS'(1);
            end
         end

         tta_pkg::ST_MAP: begin
            // Step for an output axis: its stride minus the rewind of all inner axes.
            if (tta_pkg::RANK_BITS'(k_ff) < rank_ff) begin
               ext_in[k_ff]   = shape_eff;
               delta_in[k_ff] = in_stride_ff[map_axis] - rewind_ff;
               rewind_in      = rewind_ff + span_ff[map_axis] - in_stride_ff[map_axis];
            end
            if (k_ff == '0) begin
               state_in = tta_pkg::ST_EMIT;
            end else begin
               k_in = k_ff - K_BITS'(1);
            end
         end

         tta_pkg::ST_EMIT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_dest_in  = dest_ff;
               rsp_src_in   = src_ff;
               rsp_last_in  = last_cur;
               rsp_err_in   = err_ff;
               state_in     = tta_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tta_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      in_stride_ff <= in_stride_in;
      span_ff      <= span_in;
      rank_ff      <= rank_in;
      perm_ff      <= perm_in;
      ax_ff        <= ax_in;
      k_ff         <= k_in;
      bit_cnt_ff   <= bit_cnt_in;
      mul_e_ff     <= mul_e_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod_in;
      rewind_ff    <= rewind_in;
      rsp_dest_ff  <= rsp_dest_in;
      rsp_src_ff   <= rsp_src_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
      if (reset) begin
         state_ff     <= tta_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         src_ff       <= '0;
         dest_ff      <= '0;
         err_ff       <= tta_pkg::ERR_NONE;
         for (int i = 0; i < AXES; i++) begin
            coord_ff[i] <= '0;
            ext_ff[i]   <= E'(1);
            delta_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         src_ff       <= src_in;
         dest_ff      <= dest_in;
         err_ff       <= err_in;
         coord_ff     <= coord_in;
         ext_ff       <= ext_in;
         delta_ff     <= delta_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_dest_index = rsp_dest_ff;
   assign rsp_src_index  = rsp_src_ff;
   assign rsp_last       = rsp_last_ff;
   assign rsp_error      = rsp_err_ff;

endmodule

[tb/tensor_transpose_address_generator_unit_test.sv]
// Self-checking testbench for the tensor transpose gather address generator.
`timescale 1ns / 100ps

module tensor_transpose_address_generator_unit_test;

   localparam int BEAT_TARGET = 700;
   localparam int CYCLE_LIMIT = 500000;
   localparam int SETTLE_CYCLES = 100;
   localparam logic [tta_pkg::CSR_INDEX_BITS-1:0] CSR_UNMAPPED = 3'd7;

   typedef struct packed {
      logic [tta_pkg::RANK_BITS-1:0]      rank;
      logic [tta_pkg::PERM_BITS-1:0]      perm;
      logic                               rev;
      logic [tta_pkg::HW_AXES-1:0][15:0]  shape;
   } csr_set_type;

   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] src;
      logic        last;
      logic [1:0]  err;
   } gather_addr_type;

   typedef struct packed {
      logic restart;
      logic drain;
   } pending_beat_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [tta_pkg::CSR_INDEX_BITS-1:0] csr_index = tta_pkg::CSR_RANK;
   logic [15:0] csr_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_restart = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [31:0] rsp_dest_index;
   logic [31:0] rsp_src_index;
   logic rsp_last;
   logic [1:0] rsp_error;

   // Register contents as written, and the pass latched at the last restart.
   csr_set_type csr_shadow;
   logic [tta_pkg::HW_AXES-1:0][15:0] coord = '0;
   logic [tta_pkg::HW_AXES-1:0][15:0] extent = {tta_pkg::HW_AXES{16'd1}};
   logic [tta_pkg::HW_AXES-1:0][31:0] stride = '0;
   logic [31:0] src_at = '0;
   logic [31:0] dest_at = '0;
   tta_pkg::error_code_type pass_error = tta_pkg::ERR_NONE;

   pending_beat_type beats_to_send[$];
   gather_addr_type addresses_due[$];
   int unsigned beats_queued = 0;
   int unsigned beats_accepted = 0;
   int mismatches = 0;
   int cycle_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   tensor_transpose_address_generator_unit DUT (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_restart    (req_restart),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_dest_index (rsp_dest_index),
      .rsp_src_index  (rsp_src_index),
      .rsp_last       (rsp_last),
      .rsp_error      (rsp_error)
   );

   always #4 clock = ~clock;

   function automatic gather_addr_type next_gather_address(logic restart);
      gather_addr_type addr;
      logic [tta_pkg::HW_AXES-1:0][1:0] feed;
      logic [tta_pkg::HW_AXES-1:0][15:0] in_ext;
      logic [tta_pkg::HW_AXES-1:0][31:0] in_stride;
      logic [63:0] count;
      logic [63:0] sum;
      int rank;
      int mask;
      logic carry;
      if (restart) begin
         coord = '0;
         stride = '0;
         extent = {tta_pkg::HW_AXES{16'd1}};
         src_at = '0;
         dest_at = '0;
         pass_error = tta_pkg::ERR_NONE;
         rank = csr_shadow.rank;
         mask = 0;
         if (rank < 1 || rank > tta_pkg::HW_AXES) begin
            pass_error = tta_pkg::ERR_PERM;
         end else begin
            for (int i = 0; i < rank; i++) begin
               feed[i] = csr_shadow.rev ? 2'(rank - 1 - i) : csr_shadow.perm[2*i +: 2];
               if (feed[i] < rank)
                  mask |= 1 << feed[i];
            end
            if (mask != (1 << rank) - 1)
               pass_error = tta_pkg::ERR_PERM;
         end
         // The element count may reach exactly 2**32 but not pass it.
         count = 64'd1;
         for (int i = 0; i < rank && pass_error == tta_pkg::ERR_NONE; i++) begin
            in_ext[i] = (csr_shadow.shape[i] == 16'd0) ? 16'd1 : csr_shadow.shape[i];
            if (count * in_ext[i] > 64'h1_0000_0000)
               pass_error = tta_pkg::ERR_RANGE;
            else
               count = count * in_ext[i];
         end
         if (pass_error == tta_pkg::ERR_NONE) begin
            in_stride[rank-1] = 32'd1;
            for (int a = rank - 2; a >= 0; a--)
               in_stride[a] = in_stride[a+1] * 32'(in_ext[a+1]);
            for (int i = 0; i < rank; i++) begin
               extent[i] = in_ext[feed[i]];
               stride[i] = in_stride[feed[i]];
            end
         end
      end else begin
         carry = 1'b1;
         for (int i = tta_pkg::HW_AXES - 1; i >= 0; i--) begin
            if (carry) begin
               if (32'(coord[i]) + 1 < 32'(extent[i])) begin
                  coord[i] = coord[i] + 16'd1;
                  carry = 1'b0;
               end else begin
                  coord[i] = '0;
               end
            end
         end
         dest_at = carry ? 32'd0 : dest_at + 32'd1;
         sum = '0;
         for (int i = 0; i < tta_pkg::HW_AXES; i++)
            sum += 64'(coord[i]) * 64'(stride[i]);
         src_at = sum[31:0];
      end
      addr.last = 1'b1;
      for (int i = 0; i < tta_pkg::HW_AXES; i++)
         if (32'(coord[i]) + 1 != 32'(extent[i]))
            addr.last = 1'b0;
      addr.dest = dest_at;
      addr.src = src_at;
      addr.err = pass_error;
      return addr;
   endfunction

   function automatic csr_set_type make_cfg(logic [2:0] rank, logic [7:0] perm, logic rev,
                                            logic [15:0] s0, logic [15:0] s1,
                                            logic [15:0] s2, logic [15:0] s3);
      csr_set_type c;
      c.rank = rank;
      c.perm = perm;
      c.rev = rev;
      c.shape = {s3, s2, s1, s0};
      return c;
   endfunction

   function automatic csr_set_type random_config();
      csr_set_type c;
      int order [tta_pkg::HW_AXES];
      int j;
      int t;
      int pick;
      if ($urandom_range(99) < 88) begin
         c.rank = 3'($urandom_range(1, tta_pkg::HW_AXES));
      end else begin
         pick = $urandom_range(0, 3);
         c.rank = 3'((pick == 0) ? 0 : tta_pkg::HW_AXES + pick);
      end
      c.perm = 8'($urandom);
      // Mostly a complete permutation of the axes in use; upper fields stay random.
      if ($urandom_range(99) < 75) begin
         for (int i = 0; i < tta_pkg::HW_AXES; i++)
            order[i] = i;
         for (int i = tta_pkg::HW_AXES - 1; i > 0; i--) begin
            if (i < c.rank) begin
               j = $urandom_range(0, i);
               t = order[i];
               order[i] = order[j];
               order[j] = t;
            end
         end
         for (int i = 0; i < tta_pkg::HW_AXES; i++)
            if (i < c.rank)
               c.perm[2*i +: 2] = 2'(order[i]);
      end
      c.rev = ($urandom_range(99) < 30);
      for (int i = 0; i < tta_pkg::HW_AXES; i++) begin
         if (i >= c.rank || $urandom_range(99) < 10)
            c.shape[i] = 16'($urandom);
         else
            c.shape[i] = 16'($urandom_range(0, 4));
      end
      return c;
   endfunction

   // Leaves csr_valid high so that back-to-back writes keep one beat per edge.
   task automatic write_csr(logic [tta_pkg::CSR_INDEX_BITS-1:0] idx, logic [15:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(csr_set_type c);
      write_csr(tta_pkg::CSR_RANK, {13'($urandom), c.rank});
      write_csr(tta_pkg::CSR_PERMUTATION, {8'($urandom), c.perm});
      write_csr(tta_pkg::CSR_REVERSE, {15'($urandom), c.rev});
      write_csr(tta_pkg::CSR_SHAPE0, c.shape[0]);
      write_csr(tta_pkg::CSR_SHAPE1, c.shape[1]);
      write_csr(tta_pkg::CSR_SHAPE2, c.shape[2]);
      write_csr(tta_pkg::CSR_SHAPE3, c.shape[3]);
      write_csr(CSR_UNMAPPED, 16'($urandom));
      csr_valid <= 1'b0;
      csr_shadow = c;
   endtask

   task automatic queue_beat(logic restart, logic drain);
      pending_beat_type b;
      b.restart = restart;
      b.drain = drain;
      beats_to_send.insert(beats_to_send.size(), b);
      beats_queued++;
   endtask

   task automatic queue_pass(logic restart, int advances);
      queue_beat(restart, 1'b0);
      for (int i = 0; i < advances; i++)
         queue_beat(1'b0, 1'b0);
   endtask

   // Returns on a rising edge once every queued beat is in and every address is out.
   task automatic settle();
      @(posedge clock);
      while (beats_accepted != beats_queued || addresses_due.size() != 0)
         @(posedge clock);
   endtask

   always @(posedge clock) begin : driver
      pending_beat_type beat;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            addresses_due.insert(addresses_due.size(), next_gather_address(req_restart));
            beats_accepted++;
         end
         if (!req_valid || !req_stall) begin
            if (beats_to_send.size() != 0
                && !(beats_to_send[0].drain && addresses_due.size() != 0)
                && $urandom_range(99) >= send_idle_pct) begin
               beat = beats_to_send.pop_front();
               req_valid <= 1'b1;
               req_restart <= beat.restart;
            end else begin
               req_valid <= 1'b0;
               req_restart <= 1'($urandom);
            end
         end
      end
   end

   always @(posedge clock) begin : monitor
      gather_addr_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (addresses_due.size() == 0) begin
               $display("%0t ns: result beat with none expected, dest_index %h src_index %h",
                        $time, rsp_dest_index, rsp_src_index);
               mismatches++;
            end else begin
               want = addresses_due.pop_front();
               if (rsp_dest_index !== want.dest) begin
                  $display("%0t ns: dest_index expected %h, actual %h",
                           $time, want.dest, rsp_dest_index);
                  mismatches++;
               end
               if (rsp_src_index !== want.src) begin
                  $display("%0t ns: src_index expected %h, actual %h",
                           $time, want.src, rsp_src_index);
                  mismatches++;
               end
               if (rsp_last !== want.last) begin
                  $display("%0t ns: last expected %b, actual %b", $time, want.last, rsp_last);
                  mismatches++;
               end
               if (rsp_error !== want.err) begin
                  $display("%0t ns: error expected %0d, actual %0d",
                           $time, want.err, rsp_error);
                  mismatches++;
               end
            end
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      int phase;
      int n;
      int random_beats;
      csr_shadow = make_cfg(3'd1, 8'd228, 1'b1, 16'd1, 16'd1, 16'd1, 16'd1);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Advancing before any restart walks a one-element pass.
      queue_pass(1'b0, 1);
      settle();
      // Full rank with a mixed permutation, walked past its end so it wraps.
      write_config(make_cfg(3'd4, {2'd1, 2'd3, 2'd0, 2'd2}, 1'b0, 16'd2, 16'd1, 16'd2, 16'd1));
      queue_pass(1'b1, 4);
      settle();
      // Reversed axes with a large stride on the fastest output axis.
      write_config(make_cfg(3'd3, 8'd0, 1'b1, 16'd3, 16'd65535, 16'd21845, 16'd0));
      queue_pass(1'b1, 2);
      settle();
      // Exactly 2**32 elements is still in range; one more extent step is not.
      write_config(make_cfg(3'd4, 8'd228, 1'b0, 16'd256, 16'd256, 16'd256, 16'd256));
      queue_pass(1'b1, 1);
      settle();
      write_config(make_cfg(3'd4, 8'd228, 1'b0, 16'd256, 16'd256, 16'd256, 16'd257));
      queue_pass(1'b1, 1);
      settle();
      // Rank zero and rank above the axis count.
      write_config(make_cfg(3'd0, 8'd228, 1'b1, 16'd65535, 16'd65535, 16'd65535, 16'd65535));
      queue_pass(1'b1, 0);
      settle();
      write_config(make_cfg(3'd7, 8'd228, 1'b1, 16'd65535, 16'd65535, 16'd65535, 16'd65535));
      queue_pass(1'b1, 0);
      settle();
      // A repeated axis is reported even though the extents also overflow.
      write_config(make_cfg(3'd3, {2'd3, 2'd0, 2'd1, 2'd1}, 1'b0,
                            16'd65535, 16'd65535, 16'd65535, 16'd65535));
      queue_pass(1'b1, 1);
      settle();
      // Zero extents count as one.
      write_config(make_cfg(3'd1, 8'hFC, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
      queue_pass(1'b1, 2);
      settle();
      // A write in the middle of a pass waits for the next restart.
      write_config(make_cfg(3'd2, 8'd0, 1'b1, 16'd2, 16'd3, 16'd0, 16'd0));
      queue_pass(1'b1, 1);
      settle();
      write_config(make_cfg(3'd1, 8'hFC, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
      queue_pass(1'b0, 1);
      queue_pass(1'b1, 0);

      phase = 0;
      random_beats = 0;
      while (random_beats < BEAT_TARGET) begin
         settle();
         write_config(random_config());
         case (phase % 4)
            0: begin
               send_idle_pct = 0;
               stall_pct = 0;
            end
            1: begin
               send_idle_pct = 54;
               stall_pct = 0;
            end
            2: begin
               send_idle_pct = 0;
               stall_pct = 54;
            end
            default: begin
               send_idle_pct = 27;
               stall_pct = 27;
            end
         endcase
         n = $urandom_range(20, 60);
         for (int k = 0; k < n; k++) begin
            if (k == 0)
               queue_beat($urandom_range(99) < 85, 1'b0);
            else
               queue_beat($urandom_range(99) < 3, $urandom_range(99) < 2);
         end
         random_beats += n;
         phase++;
      end

      settle();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

[filelist.f]
hdl/tta_pkg.sv
hdl/tta_front.sv
hdl/tta_queue.sv
hdl/tta_back.sv
hdl/tensor_transpose_address_generator_unit.sv
tb/tensor_transpose_address_generator_unit_test.sv
